// File: rtl/core/psg_three_voice_synth_assert.svh
// Assertion macros for the three-voice sound generator.
// Used by psg_three_voice_synth; needs no other file.
`ifndef PSG_THREE_VOICE_SYNTH_ASSERT_SVH
`define PSG_THREE_VOICE_SYNTH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psg assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psg assertion failed");

`endif

// File: rtl/core/psg_pkg.sv
// Types and constants for the three-voice sound generator.
// Used by psg_three_voice_synth; depends on nothing.
`timescale 1ns / 1ps

package psg_pkg;

   // Command codes carried in the cmd field.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef logic [3:0] psg_addr_type;

   // Sound register indexes.
   localparam psg_addr_type REG_NOISE      = 4'd6;
   localparam psg_addr_type REG_MIXER      = 4'd7;
   localparam psg_addr_type REG_ENV_FINE   = 4'd11;
   localparam psg_addr_type REG_ENV_COARSE = 4'd12;
   localparam psg_addr_type REG_ENV_SHAPE  = 4'd13;
   localparam psg_addr_type TONE_FINE_REG   [3] = '{4'd0, 4'd2, 4'd4};
   localparam psg_addr_type TONE_COARSE_REG [3] = '{4'd1, 4'd3, 4'd5};
   localparam psg_addr_type AMP_REG         [3] = '{4'd8, 4'd9, 4'd10};

   // Bit positions inside the amplitude and shape registers.
   localparam int AMP_ENV_BIT = 4;
   localparam int SHAPE_HOLD  = 0;
   localparam int SHAPE_ALT   = 1;
   localparam int SHAPE_ATK   = 2;
   localparam int SHAPE_CONT  = 3;

   // DAC curve in fixed point, full scale 8191.
   localparam logic [12:0] FULL_SCALE = 13'd8191;
   localparam logic [12:0] DAC_TABLE [16] = '{
      13'd0,    13'd81,   13'd118,  13'd172,  13'd251,  13'd373,  13'd528,  13'd879,
      13'd1036, 13'd1679, 13'd2393, 13'd3053, 13'd4034, 13'd5203, 13'd6598, 13'd8191
   };

   typedef enum logic [1:0] {
      ENV_NONE = 2'd0,
      ENV_UP   = 2'd1,
      ENV_DOWN = 2'd2
   } psg_env_dir_type;

   typedef struct packed {
      psg_env_dir_type dir;
      logic [3:0]      step;
   } psg_env_type;

   typedef struct packed {
      logic         cmd;
      psg_addr_type reg_addr;
      logic [7:0]   reg_data;
      logic         buzzer;
   } psg_req_type;

   typedef struct packed {
      logic [14:0] sample;
      logic [3:0]  level_a;
      logic [3:0]  level_b;
      logic [3:0]  level_c;
      logic [3:0]  env_level;
   } psg_rsp_type;

endpackage

// File: rtl/core/psg_three_voice_synth.sv
// Three-voice sound generator: register file, tone/noise/envelope state and mixer.
// Depends on psg_pkg and psg_three_voice_synth_assert.svh.
`timescale 1ns / 1ps
`include "psg_three_voice_synth_assert.svh"

// Usage:
// The req channel carries one beat per register write or chip clock tick. A write
// stores reg_data into the addressed sound register; a write to the shape register
// restarts the envelope on the next working tick. Every second tick advances the
// three tone dividers, the 17-bit noise shift register and the envelope.
// Every req beat yields exactly one rsp beat with the mixed sample, the per-voice
// DAC indexes and the envelope step as they stand after that beat.
// The rsp beat is valid in the cycle after the req beat.
// Throughput is one beat per cycle while the receiver takes each result; the state update and the mix are a single
// pass of logic between the state registers and the result register.
// When the receiver stalls, the result register holds its beat and req_ready
// drops until it is taken; req_ready is high again in the cycle the result leaves.
// Synchronous reset clears all sound registers, counters and the envelope,
// loads the noise shift register with one and empties the result register.
module psg_three_voice_synth (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  psg_pkg::psg_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output psg_pkg::psg_rsp_type rsp_data
);
   import psg_pkg::*;

   // Architectural state.
   logic [7:0]  reg_file_ff [16];
   logic [7:0]  reg_file_in [16];
   logic        half_clock_ff, half_clock_in;
   logic [14:0] tone_count_ff [3];
   logic [14:0] tone_count_in [3];
   logic [2:0]  tone_out_ff, tone_out_in;
   logic [8:0]  noise_count_ff, noise_count_in;
   logic [16:0] noise_lfsr_ff, noise_lfsr_in;
   logic [19:0] env_count_ff, env_count_in;
   psg_env_type env_ff, env_in;
   logic [3:0]  chan_volume_ff [3];
   logic [3:0]  chan_volume_in [3];
   logic        env_restart_ff, env_restart_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   psg_rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire;

   // One envelope step at the end of an envelope period.
   function automatic psg_env_type env_advance(input psg_env_type cur, input logic [7:0] shape);
      psg_env_type nxt;
      logic        at_end;
      nxt    = cur;
      at_end = ((cur.dir == ENV_DOWN) && (cur.step == 4'd0)) ||
               ((cur.dir == ENV_UP) && (cur.step == 4'hF));
      if (at_end) begin
         if (!shape[SHAPE_CONT]) begin
            nxt.step = 4'd0;
            nxt.dir  = ENV_NONE;
         end else begin
            if (shape[SHAPE_ALT]) begin
               nxt.dir = (cur.dir == ENV_UP) ? ENV_DOWN : ENV_UP;
            end else begin
               nxt.step = (cur.dir == ENV_UP) ? 4'd0 : 4'hF;
            end
            if (shape[SHAPE_HOLD]) begin
               nxt.step = (nxt.dir == ENV_UP) ? 4'hF : 4'd0;
               nxt.dir  = ENV_NONE;
            end
         end
      end else begin
         case (cur.dir)
            ENV_UP:   nxt.step = cur.step + 4'd1;
            ENV_DOWN: nxt.step = cur.step - 4'd1;
            default:  nxt.step = cur.step;
         endcase
      end
      return nxt;
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Next state for one accepted beat.
   always_comb begin
      logic [11:0] tone_period;
      logic [4:0]  noise_period;
      logic [15:0] env_period;
      logic [14:0] tcount;
      logic [8:0]  ncount;
      logic [19:0] ecount;
      logic [7:0]  amp;

      tone_period  = 12'd0;
      noise_period = 5'd0;
      env_period   = 16'd0;
      tcount       = 15'd0;
      ncount       = 9'd0;
      ecount       = 20'd0;
      amp          = 8'd0;

      reg_file_in    = reg_file_ff;
      half_clock_in  = half_clock_ff;
      tone_count_in  = tone_count_ff;
      tone_out_in    = tone_out_ff;
      noise_count_in = noise_count_ff;
      noise_lfsr_in  = noise_lfsr_ff;
      env_count_in   = env_count_ff;
      env_in         = env_ff;
      chan_volume_in = chan_volume_ff;
      env_restart_in = env_restart_ff;

      if (req_fire) begin
         if (req_data.cmd == CMD_WRITE) begin
            reg_file_in[req_data.reg_addr] = req_data.reg_data;
            if (req_data.reg_addr == REG_ENV_SHAPE) begin
               env_restart_in = 1'b1;
            end
         end else begin
            half_clock_in = ~half_clock_ff;
            // Work happens on the tick that brings the half clock back to zero.
            if (half_clock_ff) begin
               // Tone dividers; a voice whose low five amplitude bits are zero stands still.
               for (int i = 0; i < 3; i++) begin
                  amp = reg_file_ff[AMP_REG[i]];
                  if (!amp[AMP_ENV_BIT]) begin
                     chan_volume_in[i] = amp[3:0];
                  end
                  if (amp[4:0] != 5'd0) begin
                     tcount = tone_count_ff[i];
                     if (tcount == 15'd0) begin
                        tone_period = {reg_file_ff[TONE_COARSE_REG[i]][3:0],
                                       reg_file_ff[TONE_FINE_REG[i]]};
                        if (tone_period == 12'd0) begin
                           tone_period = 12'd1;
                        end
                        tone_out_in[i] = ~tone_out_ff[i];
                        tcount         = {tone_period, 3'b000};
                     end
                     tone_count_in[i] = tcount - 15'd1;
                  end
               end

               // Noise divider and shift register; idle while the period register is zero.
               if (reg_file_ff[REG_NOISE] != 8'd0) begin
                  ncount = noise_count_ff;
                  if (ncount == 9'd0) begin
                     noise_period = reg_file_ff[REG_NOISE][4:0];
                     if (noise_period == 5'd0) begin
                        noise_period = 5'd1;
                     end
                     noise_lfsr_in = {noise_lfsr_ff[0] ^ noise_lfsr_ff[3], noise_lfsr_ff[16:1]};
                     ncount        = {noise_period, 4'b0000};
                  end
                  noise_count_in = ncount - 9'd1;
               end

               // Envelope restart after a shape write.
               if (env_restart_ff) begin
                  if (reg_file_ff[REG_ENV_SHAPE][SHAPE_ATK]) begin
                     env_in.dir  = ENV_UP;
                     env_in.step = 4'd0;
                  end else begin
                     env_in.dir  = ENV_DOWN;
                     env_in.step = 4'hF;
                  end
               end

               // Envelope divider; voices in envelope mode follow the step.
               ecount = env_count_ff;
               if (ecount == 20'd0) begin
                  env_in = env_advance(env_in, reg_file_ff[REG_ENV_SHAPE]);
                  for (int i = 0; i < 3; i++) begin
                     if (reg_file_ff[AMP_REG[i]][AMP_ENV_BIT]) begin
                        chan_volume_in[i] = env_in.step;
                     end
                  end
                  env_period = {reg_file_ff[REG_ENV_COARSE], reg_file_ff[REG_ENV_FINE]};
                  if (env_period == 16'd0) begin
                     env_period = 16'd1;
                  end
                  ecount = {env_period, 4'b0000};
               end
               env_count_in   = ecount - 20'd1;
               env_restart_in = 1'b0;
            end
         end
      end
   end

   // Mixer and DAC sum on the updated state.
   always_comb begin
      logic [7:0] mixer;
      logic [3:0] lvl [3];
      mixer = reg_file_in[REG_MIXER];
      for (int i = 0; i < 3; i++) begin
         if ((tone_out_in[i] || mixer[i]) && (noise_lfsr_in[0] || mixer[i + 3])) begin
            lvl[i] = chan_volume_in[i];
         end else begin
            lvl[i] = 4'd0;
         end
      end
      rsp_data_in.level_a   = lvl[0];
      rsp_data_in.level_b   = lvl[1];
      rsp_data_in.level_c   = lvl[2];
      rsp_data_in.env_level = env_in.step;
      rsp_data_in.sample    = 15'(DAC_TABLE[lvl[0]]) + 15'(DAC_TABLE[lvl[1]]) +
                              15'(DAC_TABLE[lvl[2]]) +
                              (req_data.buzzer ? 15'(FULL_SCALE) : 15'd0);
   end

   // Result handshake: load on an accepted beat, clear when taken.
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            reg_file_ff[i] <= 8'd0;
         end
         for (int i = 0; i < 3; i++) begin
            tone_count_ff[i]  <= 15'd0;
            chan_volume_ff[i] <= 4'd0;
         end
         half_clock_ff  <= 1'b0;
         tone_out_ff    <= 3'b000;
         noise_count_ff <= 9'd0;
         noise_lfsr_ff  <= 17'd1;
         env_count_ff   <= 20'd0;
         env_ff.dir     <= ENV_NONE;
         env_ff.step    <= 4'd0;
         env_restart_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         reg_file_ff    <= reg_file_in;
         tone_count_ff  <= tone_count_in;
         chan_volume_ff <= chan_volume_in;
         half_clock_ff  <= half_clock_in;
         tone_out_ff    <= tone_out_in;
         noise_count_ff <= noise_count_in;
         noise_lfsr_ff  <= noise_lfsr_in;
         env_count_ff   <= env_count_in;
         env_ff         <= env_in;
         env_restart_ff <= env_restart_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted beat produces a result in the next cycle.
   `PSG_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, req_fire, rsp_valid_ff)
   // A held result blocks the input side.
   `PSG_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready)
   // Each accepted tick flips the half clock.
   `PSG_ASSERT_NEXT(a_tick_flips_half, clock, reset, req_fire && (req_data.cmd == CMD_TICK),
      half_clock_ff != $past(half_clock_ff))
   // A shape write arms the envelope restart.
   `PSG_ASSERT_NEXT(a_shape_arms_restart, clock, reset,
      req_fire && (req_data.cmd == CMD_WRITE) && (req_data.reg_addr == REG_ENV_SHAPE),
      env_restart_ff)
   // A working tick consumes the restart request.
   `PSG_ASSERT_NEXT(a_work_clears_restart, clock, reset,
      req_fire && (req_data.cmd == CMD_TICK) && half_clock_ff, !env_restart_ff)

endmodule

// File: tb/tb_psg_three_voice_synth.sv
// Self-checking testbench for psg_three_voice_synth: register writes and clock ticks
// go in with random bursts and receiver stalls, and every result beat is compared
// against an in-bench model of the sound generator. Depends on psg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_psg_three_voice_synth;
   import psg_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BEATS = 1400;
   // Spare registers that are only stored.
   localparam psg_addr_type REG_SPARE_A = 4'd14;
   localparam psg_addr_type REG_SPARE_B = 4'd15;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   psg_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   psg_rsp_type rsp_data;

   psg_three_voice_synth dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Stimulus waiting to be sent and mix results waiting to arrive.
   psg_req_type pending_beats [$];
   psg_rsp_type expected_mix [$];

   int total_beats = 0;
   int beats_taken = 0;
   int write_count = 0;
   int tick_count = 0;
   int mix_checked = 0;
   int error_count = 0;
   int cycle_count = 0;

   // Shadow copy of the sound generator state.
   logic [7:0]      snd_regs [16];
   logic            half_phase;
   logic [14:0]     tone_cnt [3];
   logic [2:0]      tone_level;
   logic [8:0]      noise_cnt;
   logic [16:0]     noise_sr;
   logic [19:0]     env_cnt;
   logic [3:0]      env_pos;
   psg_env_dir_type env_way;
   logic [3:0]      voice_vol [3];
   logic            env_rearm;

   // Apply one beat to the shadow state and return the mix the block must produce.
   function automatic psg_rsp_type synth_step(input psg_req_type beat);
      psg_rsp_type res;
      logic [14:0] mix;
      logic [3:0]  lvl;
      logic [7:0]  amp;
      logic [7:0]  mixer;
      logic [7:0]  shape;
      logic [11:0] tone_period;
      logic [4:0]  noise_period;
      logic [15:0] env_period;
      int          v;
      res = '0;
      mix = '0;
      if (beat.cmd == CMD_WRITE) begin
         snd_regs[beat.reg_addr] = beat.reg_data;
         if (beat.reg_addr == REG_ENV_SHAPE) begin
            env_rearm = 1'b1;
         end
      end else begin
         half_phase = ~half_phase;
         // Only every second tick does any work.
         if (!half_phase) begin
            for (v = 0; v < 3; v++) begin
               amp = snd_regs[AMP_REG[v]];
               if (!amp[AMP_ENV_BIT]) begin
                  voice_vol[v] = amp[3:0];
               end
               // A voice with a silent amplitude register keeps its divider frozen.
               if (amp[4:0] != 5'd0) begin
                  if (tone_cnt[v] == 15'd0) begin
                     tone_period = {snd_regs[TONE_COARSE_REG[v]][3:0], snd_regs[TONE_FINE_REG[v]]};
                     if (tone_period == 12'd0) begin
                        tone_period = 12'd1;
                     end
                     tone_level[v] = ~tone_level[v];
                     tone_cnt[v] = {tone_period, 3'b000};
                  end
                  tone_cnt[v] = tone_cnt[v] - 15'd1;
               end
            end

            // Noise runs whenever its register is nonzero, even if the period bits are zero.
            if (snd_regs[REG_NOISE] != 8'd0) begin
               if (noise_cnt == 9'd0) begin
                  noise_period = snd_regs[REG_NOISE][4:0];
                  if (noise_period == 5'd0) begin
                     noise_period = 5'd1;
                  end
                  noise_sr = {noise_sr[0] ^ noise_sr[3], noise_sr[16:1]};
                  noise_cnt = {noise_period, 4'b0000};
               end
               noise_cnt = noise_cnt - 9'd1;
            end

            // A shape write restarts direction and step but leaves the counter alone.
            shape = snd_regs[REG_ENV_SHAPE];
            if (env_rearm) begin
               if (shape[SHAPE_ATK]) begin
                  env_way = ENV_UP;
                  env_pos = 4'd0;
               end else begin
                  env_way = ENV_DOWN;
                  env_pos = 4'd15;
               end
            end

            if (env_cnt == 20'd0) begin
               if ((env_way == ENV_DOWN && env_pos == 4'd0) ||
                   (env_way == ENV_UP && env_pos == 4'd15)) begin
                  // End of a ramp: stop, wrap, turn around and maybe hold.
                  if (!shape[SHAPE_CONT]) begin
                     env_pos = 4'd0;
                     env_way = ENV_NONE;
                  end else begin
                     if (shape[SHAPE_ALT]) begin
                        env_way = (env_way == ENV_UP) ? ENV_DOWN : ENV_UP;
                     end else begin
                        env_pos = (env_way == ENV_UP) ? 4'd0 : 4'd15;
                     end
                     if (shape[SHAPE_HOLD]) begin
                        env_pos = (env_way == ENV_UP) ? 4'd15 : 4'd0;
                        env_way = ENV_NONE;
                     end
                  end
               end else if (env_way == ENV_UP) begin
                  env_pos = env_pos + 4'd1;
               end else if (env_way == ENV_DOWN) begin
                  env_pos = env_pos - 4'd1;
               end
               for (v = 0; v < 3; v++) begin
                  if (snd_regs[AMP_REG[v]][AMP_ENV_BIT]) begin
                     voice_vol[v] = env_pos;
                  end
               end
               env_period = {snd_regs[REG_ENV_COARSE], snd_regs[REG_ENV_FINE]};
               if (env_period == 16'd0) begin
                  env_period = 16'd1;
               end
               env_cnt = {env_period, 4'b0000};
            end
            env_cnt = env_cnt - 20'd1;
            env_rearm = 1'b0;
         end
      end

      // Mixer gates each voice by its tone and noise enables, then the DAC curve sums them.
      mixer = snd_regs[REG_MIXER];
      for (v = 0; v < 3; v++) begin
         lvl = ((tone_level[v] | mixer[v]) & (noise_sr[0] | mixer[v + 3])) ? voice_vol[v] : 4'd0;
         mix = mix + 15'(DAC_TABLE[lvl]);
         case (v)
            0: res.level_a = lvl;
            1: res.level_b = lvl;
            default: res.level_c = lvl;
         endcase
      end
      if (beat.buzzer) begin
         mix = mix + 15'(FULL_SCALE);
      end
      res.sample = mix;
      res.env_level = env_pos;
      return res;
   endfunction

   // Register contents biased toward short periods so that dividers and envelope turn over.
   function automatic logic [7:0] pick_value(input psg_addr_type addr);
      logic [7:0] val;
      int         v;
      val = 8'($urandom);
      for (v = 0; v < 3; v++) begin
         if (addr == TONE_FINE_REG[v]) begin
            val = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 31))
                                              : 8'($urandom_range(0, 15));
         end
         if (addr == TONE_COARSE_REG[v]) begin
            val = {4'($urandom), 4'h0};
         end
         if (addr == AMP_REG[v] && $urandom_range(0, 3) == 0) begin
            val = {3'($urandom), 5'b00000};
         end
      end
      if (addr == REG_NOISE) begin
         case ($urandom_range(0, 5))
            0: val = 8'd0;
            1: val = {3'($urandom), 5'b00000};
            2: val = 8'($urandom);
            default: val = {3'($urandom), 5'($urandom_range(1, 3))};
         endcase
      end
      if (addr == REG_ENV_FINE) begin
         val = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(4, 15))
                                           : 8'($urandom_range(0, 3));
      end
      if (addr == REG_ENV_COARSE) begin
         val = 8'd0;
      end
      return val;
   endfunction

   // Queue one beat; ticks carry random don't-care address and data.
   task automatic add_beat(input logic cmd, input psg_addr_type addr, input logic [7:0] data);
      psg_req_type beat;
      beat.cmd = cmd;
      beat.reg_addr = (cmd == CMD_WRITE) ? addr : psg_addr_type'($urandom);
      beat.reg_data = (cmd == CMD_WRITE) ? data : 8'($urandom);
      beat.buzzer = 1'($urandom);
      pending_beats.push_back(beat);
   endtask

   task automatic add_ticks(input int count);
      for (int n = 0; n < count; n++) begin
         add_beat(CMD_TICK, REG_NOISE, 8'd0);
      end
   endtask

   // Driver: sends pending beats in bursts and predicts each one as it is accepted.
   int burst_left = 8;
   int gap_left = 0;
   always @(posedge clock) begin : drive_req
      psg_rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         for (int r = 0; r < 16; r++) begin
            snd_regs[r] = 8'd0;
         end
         for (int v = 0; v < 3; v++) begin
            tone_cnt[v] = 15'd0;
            voice_vol[v] = 4'd0;
         end
         tone_level = 3'b000;
         half_phase = 1'b0;
         noise_cnt = 9'd0;
         noise_sr = 17'd1;
         env_cnt = 20'd0;
         env_pos = 4'd0;
         env_way = ENV_NONE;
         env_rearm = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            want = synth_step(req_data);
            expected_mix.push_back(want);
            beats_taken++;
            if (req_data.cmd == CMD_WRITE) begin
               write_count++;
            end else begin
               tick_count++;
            end
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_beats.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 60);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void report_field(input string what, input int unsigned want,
                                        input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   // Monitor: checks each result beat and stalls the result channel on a rotating pattern.
   logic [15:0] stall_pat = 16'hFFFF;
   int          stall_left = 0;
   always @(posedge clock) begin : watch_rsp
      psg_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_mix.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_mix.pop_front();
               report_field("sample", want.sample, rsp_data.sample);
               report_field("level_a", want.level_a, rsp_data.level_a);
               report_field("level_b", want.level_b, rsp_data.level_b);
               report_field("level_c", want.level_c, rsp_data.level_c);
               report_field("env_level", want.env_level, rsp_data.env_level);
               mix_checked++;
            end
         end
         if (stall_left == 0) begin
            stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            stall_left = 16;
         end
         rsp_ready <= stall_pat[0];
         stall_pat = {stall_pat[0], stall_pat[15:1]};
         stall_left--;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_mix.size());
         $display("tb_psg_three_voice_synth NOT OK");
         $finish;
      end
   end

   // Stimulus plan, reset and end of run.
   initial begin
      psg_addr_type addr;
      int           n_writes;

      // Directed part: half tick, zero periods, silent voice, noise register with
      // zero period bits, shape writes and data extremes.
      add_ticks(2);
      add_beat(CMD_WRITE, AMP_REG[0], 8'h0F);
      add_beat(CMD_WRITE, REG_MIXER, 8'h00);
      add_beat(CMD_WRITE, REG_NOISE, 8'h20);
      add_beat(CMD_WRITE, AMP_REG[1], 8'h1F);
      add_beat(CMD_WRITE, AMP_REG[2], 8'h00);
      add_beat(CMD_WRITE, REG_ENV_SHAPE, 8'h0E);
      add_beat(CMD_WRITE, REG_ENV_FINE, 8'h00);
      add_beat(CMD_WRITE, TONE_FINE_REG[0], 8'h00);
      add_beat(CMD_WRITE, REG_SPARE_A, 8'hFF);
      add_beat(CMD_WRITE, REG_SPARE_B, 8'h00);
      add_ticks(6);
      add_beat(CMD_WRITE, REG_MIXER, 8'hFF);
      add_ticks(2);
      add_beat(CMD_WRITE, REG_MIXER, 8'h00);
      add_beat(CMD_WRITE, REG_ENV_SHAPE, 8'h09);
      add_ticks(4);

      // Random part: mostly short register programs followed by runs of ticks,
      // with the odd burst of arbitrary beats.
      while (pending_beats.size() < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) == 0) begin
            n_writes = $urandom_range(3, 8);
            for (int n = 0; n < n_writes; n++) begin
               addr = psg_addr_type'($urandom);
               add_beat(1'($urandom), addr, pick_value(addr));
            end
         end else begin
            n_writes = $urandom_range(1, 5);
            for (int n = 0; n < n_writes; n++) begin
               addr = psg_addr_type'($urandom);
               // Shape writes are kept rare so that envelope ramps reach their ends.
               if (addr == REG_ENV_SHAPE && $urandom_range(0, 7) != 0) begin
                  addr = REG_MIXER;
               end
               add_beat(CMD_WRITE, addr, pick_value(addr));
            end
            if ($urandom_range(0, 4) == 0) begin
               add_beat(CMD_WRITE, REG_ENV_FINE, pick_value(REG_ENV_FINE));
            end
            add_ticks($urandom_range(8, 70));
         end
      end
      total_beats = pending_beats.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken < total_beats || expected_mix.size() != 0) begin
         @(posedge clock);
      end
      // Give any stray result beat a chance to show up.
      repeat (8) @(posedge clock);

      $display("Sent %0d beats (%0d register writes, %0d clock ticks) under random bursts,",
               total_beats, write_count, tick_count);
      $display("checked %0d result beats against the model, %0d mismatches.",
               mix_checked, error_count);
      if (error_count == 0) begin
         $display("tb_psg_three_voice_synth OK");
      end else begin
         $display("tb_psg_three_voice_synth NOT OK");
      end
      $finish;
   end

endmodule
